// ----- design/sialu_pkg.sv -----
// Opcode codes and the opcode width shared by the signed integer ALU.
package sialu_pkg;

  localparam int unsigned OPCODE_W = 3;

  localparam logic [OPCODE_W-1:0] OP_ADD = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MUL = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DIV = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REM = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_ABS = 3'd5;

endpackage

// ----- design/signed_integer_alu_muldiv_unit.sv -----
// Pipelined signed integer ALU: add, subtract, multiply, divide, remainder, absolute.
//
// One item is accepted every cycle unless the pipeline is full behind a stalled output, and each result
// passes through an input register, a stage that forms magnitudes, error flags and the
// partial products of a split multiplier, one restoring-division stage per result bit,
// and an output register. Every stage holds its own valid bit and advances whenever the
// stage after it is free, so a stalled output only halts the items behind it.
// Results wrap to DATA_WIDTH bits; a zero divisor, or a negative operand of a remainder,
// returns zero with error set.
module signed_integer_alu_muldiv_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // operand_a, operand_b
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // opcode
  input  logic [sialu_pkg::OPCODE_W-1:0]           s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // result
  output logic [((DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  // error
  output logic                                     m_axis_tuser
);
  import sialu_pkg::*;

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned H     = (W + 1) / 2;
  localparam int unsigned NS    = W + 3;
  localparam int unsigned OUT_W = ((W + 7) / 8) * 8;

  logic [NS-1:0] en;
  logic [NS-1:0] vld;

  // input register
  logic                v0_q;
  logic [OPCODE_W-1:0] op0_q;
  logic [W-1:0]        a0_q, b0_q;

  // prep stage
  logic                v1_q;
  logic [OPCODE_W-1:0] op1_q;
  logic [W-1:0]        res1_q, ma1_q, mb1_q;
  logic                err1_q, neg1_q;
  logic [2*H-1:0]      mlo1_q;
  logic [H-1:0]        mcr1_q;

  // division stages
  logic                vd_q   [W];
  logic [OPCODE_W-1:0] opd_q  [W];
  logic [W-1:0]        resd_q [W];
  logic                errd_q [W];
  logic                negd_q [W];
  logic [W-1:0]        nd_q   [W];
  logic [W-1:0]        rd_q   [W];
  logic [W-1:0]        dd_q   [W];

  // output register
  logic                vo_q;
  logic [OPCODE_W-1:0] opo_q;
  logic [W-1:0]        reso_q;
  logic                erro_q;

  assign vld[0]    = v0_q;
  assign vld[1]    = v1_q;
  assign vld[NS-1] = vo_q;
  assign en[NS-1]  = !vld[NS-1] || m_axis_tready;

  genvar gi;
  generate
    for (gi = 0; gi < NS - 1; gi++) begin : g_en
      assign en[gi] = !vld[gi] || en[gi+1];
    end
    for (gi = 0; gi < W; gi++) begin : g_vld
      assign vld[gi+2] = vd_q[gi];
    end
  endgenerate

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en[0]) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && s_axis_tvalid) begin
      op0_q <= s_axis_tuser;
      a0_q  <= s_axis_tdata[W-1:0];
      b0_q  <= s_axis_tdata[2*W-1:W];
    end
  end

  logic [W-1:0]   ma1_d, mb1_d, res1_d;
  logic           err1_d;
  logic [H-1:0]   al, bl, ah, bh;
  logic [2*H-1:0] pc1, pc2;

  always_comb begin
    ma1_d  = a0_q[W-1] ? (W'(0) - a0_q) : a0_q;
    mb1_d  = b0_q[W-1] ? (W'(0) - b0_q) : b0_q;
    al     = a0_q[H-1:0];
    bl     = b0_q[H-1:0];
    ah     = H'(a0_q[W-1:H]);
    bh     = H'(b0_q[W-1:H]);
    pc1    = al * bh;
    pc2    = ah * bl;
    res1_d = '0;
    err1_d = 1'b0;
    case (op0_q)
      OP_ADD: res1_d = a0_q + b0_q;
      OP_SUB: res1_d = a0_q - b0_q;
      OP_ABS: res1_d = ma1_d;
      OP_DIV: err1_d = (b0_q == '0);
      OP_REM: err1_d = (b0_q == '0) || a0_q[W-1] || b0_q[W-1];
      default: res1_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en[1]) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1] && v0_q) begin
      op1_q  <= op0_q;
      res1_q <= res1_d;
      err1_q <= err1_d;
      neg1_q <= a0_q[W-1] ^ b0_q[W-1];
      ma1_q  <= ma1_d;
      mb1_q  <= mb1_d;
      mlo1_q <= al * bl;
      mcr1_q <= pc1[H-1:0] + pc2[H-1:0];
    end
  end

  logic [W-1:0] mul_res;
  assign mul_res = mlo1_q[W-1:0] + {mcr1_q[W-H-1:0], {H{1'b0}}};

  generate
    for (gi = 0; gi < W; gi++) begin : g_div
      logic                v_in;
      logic [OPCODE_W-1:0] op_in;
      logic [W-1:0]        res_in, n_in, r_in, d_in;
      logic                err_in, neg_in;
      logic [W:0]          r_t, diff;

      if (gi == 0) begin : g_first
        assign v_in   = v1_q;
        assign op_in  = op1_q;
        assign res_in = (op1_q == OP_MUL) ? mul_res : res1_q;
        assign err_in = err1_q;
        assign neg_in = neg1_q;
        assign n_in   = ma1_q;
        assign r_in   = '0;
        assign d_in   = mb1_q;
      end else begin : g_next
        assign v_in   = vd_q[gi-1];
        assign op_in  = opd_q[gi-1];
        assign res_in = resd_q[gi-1];
        assign err_in = errd_q[gi-1];
        assign neg_in = negd_q[gi-1];
        assign n_in   = nd_q[gi-1];
        assign r_in   = rd_q[gi-1];
        assign d_in   = dd_q[gi-1];
      end

      assign r_t  = {r_in, n_in[W-1]};
      assign diff = r_t - {1'b0, d_in};

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vd_q[gi] <= 1'b0;
        end else if (en[gi+2]) begin
          vd_q[gi] <= v_in;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[gi+2] && v_in) begin
          opd_q[gi]  <= op_in;
          resd_q[gi] <= res_in;
          errd_q[gi] <= err_in;
          negd_q[gi] <= neg_in;
          dd_q[gi]   <= d_in;
          if (!diff[W]) begin
            rd_q[gi] <= diff[W-1:0];
            nd_q[gi] <= {n_in[W-2:0], 1'b1};
          end else begin
            rd_q[gi] <= r_t[W-1:0];
            nd_q[gi] <= {n_in[W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  logic [W-1:0] reso_d;
  always_comb begin
    case (opd_q[W-1])
      OP_DIV: reso_d = negd_q[W-1] ? (W'(0) - nd_q[W-1]) : nd_q[W-1];
      OP_REM: reso_d = rd_q[W-1];
      default: reso_d = resd_q[W-1];
    endcase
    if (errd_q[W-1]) begin
      reso_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en[NS-1]) begin
      vo_q <= vd_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1] && vd_q[W-1]) begin
      opo_q  <= opd_q[W-1];
      reso_q <= reso_d;
      erro_q <= errd_q[W-1];
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = OUT_W'(reso_q);
  assign m_axis_tuser  = erro_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && erro_q |-> reso_q == '0)
    else $error("error result not zero");

  a_err_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && erro_q |-> opo_q == OP_DIV || opo_q == OP_REM)
    else $error("error flag on non-divide opcode");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vo_q |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && !m_axis_tready |=> vo_q && $stable(reso_q))
    else $error("stalled result changed");

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the pipelined signed integer ALU: directed table, random items, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import sialu_pkg::*;

  localparam int unsigned DW = 32;
  localparam int unsigned IN_W = ((2*DW+7)/8)*8;
  localparam int unsigned N_RANDOM = 1200;
  localparam int unsigned LATENCY = DW + 3;
  localparam int unsigned HOLD_OFF = 200;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [DW-1:0]       a;
    logic [DW-1:0]       b;
  } alu_item_t;

  typedef struct packed {
    logic [DW-1:0] res;
    logic          err;
  } alu_res_t;

  typedef struct {
    alu_item_t item;
    logic      known;
    alu_res_t  res;
  } table_row_t;

  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] ONES = {DW{1'b1}};
  localparam logic [DW-1:0] ZERO = '0;
  localparam logic [DW-1:0] ONE  = {{(DW-1){1'b0}}, 1'b1};

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [((2*DW+7)/8)*8-1:0] s_axis_tdata;   // operand_a, operand_b
  logic [OPCODE_W-1:0] s_axis_tuser;         // opcode
  logic m_axis_tvalid, m_axis_tready;
  logic [((DW+7)/8)*8-1:0] m_axis_tdata;     // result
  logic m_axis_tuser;                        // error

  alu_res_t expected_q[$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_items;
  bit quiet_tail;
  bit hold_req;
  bit hold_done;

  signed_integer_alu_muldiv_unit #(.DATA_WIDTH(DW)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic alu_res_t alu_compute(alu_item_t it);
    alu_res_t r;
    logic [DW-1:0] mag_a, mag_b, q;
    r = '0;
    mag_a = it.a[DW-1] ? -it.a : it.a;
    mag_b = it.b[DW-1] ? -it.b : it.b;
    case (it.op)
      OP_ADD: r.res = it.a + it.b;
      OP_SUB: r.res = it.a - it.b;
      OP_MUL: r.res = it.a * it.b;
      OP_DIV: begin
        if (it.b == ZERO) begin
          r.err = 1'b1;
        end else begin
          q = mag_a / mag_b;
          r.res = (it.a[DW-1] != it.b[DW-1]) ? -q : q;
        end
      end
      OP_REM: begin
        if (it.b == ZERO || it.a[DW-1] || it.b[DW-1]) r.err = 1'b1;
        else r.res = it.a % it.b;
      end
      OP_ABS: r.res = mag_a;
      default: r = '0;
    endcase
    if (r.err) r.res = '0;
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return MINV;
      1: return MAXV;
      2: return ZERO;
      3: return ONES;
      4: return DW'($urandom_range(0, 20));
      5: return -DW'($urandom_range(1, 20));
      default: return DW'($urandom);
    endcase
  endfunction

  // drive one item and wait for its acceptance
  task automatic send_item(alu_item_t it, logic known, alu_res_t res);
    alu_res_t pred;
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pred = alu_compute(it);
    if (known && pred !== res)
      $error("table row disagrees with predictor: expected %h/%b, predicted %h/%b",
             res.res, res.err, pred.res, pred.err);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= IN_W'({it.b, it.a});
    expected_q.push_back(known ? res : pred);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk_i);
        hold_done = 1'b1;
        m_axis_tready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // check results
  always @(posedge clk_i) begin
    alu_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: result %h error %b", m_axis_tdata, m_axis_tuser);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata[DW-1:0] !== exp_r.res) begin
          $error("result: expected %h, actual %h", exp_r.res, m_axis_tdata[DW-1:0]);
          n_errors++;
        end
        if (m_axis_tuser !== exp_r.err) begin
          $error("error: expected %b, actual %b", exp_r.err, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  initial begin
    table_row_t rows[$];
    alu_item_t it;
    int unsigned wait_cycles;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ADD;
    n_errors = 0;
    n_results = 0;
    n_items = 0;
    quiet_tail = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;

    rows = '{
      '{'{OP_ADD, MAXV, ONE},  1'b1, '{MINV, 1'b0}},
      '{'{OP_ADD, ONES, ONES}, 1'b1, '{-DW'(2), 1'b0}},
      '{'{OP_SUB, MINV, ONE},  1'b1, '{MAXV, 1'b0}},
      '{'{OP_SUB, ZERO, MINV}, 1'b1, '{MINV, 1'b0}},
      '{'{OP_MUL, MAXV, MAXV}, 1'b1, '{ONE, 1'b0}},
      '{'{OP_MUL, MINV, ONES}, 1'b1, '{MINV, 1'b0}},
      '{'{OP_MUL, DW'(7), -DW'(6)}, 1'b0, '{ZERO, 1'b0}},
      '{'{OP_DIV, MINV, ONES}, 1'b1, '{MINV, 1'b0}},
      '{'{OP_DIV, DW'(5), ZERO}, 1'b1, '{ZERO, 1'b1}},
      '{'{OP_DIV, -DW'(7), DW'(2)}, 1'b1, '{-DW'(3), 1'b0}},
      '{'{OP_DIV, DW'(7), -DW'(2)}, 1'b1, '{-DW'(3), 1'b0}},
      '{'{OP_DIV, MAXV, MINV}, 1'b1, '{ZERO, 1'b0}},
      '{'{OP_DIV, MINV, MINV}, 1'b1, '{ONE, 1'b0}},
      '{'{OP_REM, DW'(17), DW'(5)}, 1'b1, '{DW'(2), 1'b0}},
      '{'{OP_REM, DW'(17), ZERO}, 1'b1, '{ZERO, 1'b1}},
      '{'{OP_REM, -DW'(17), DW'(5)}, 1'b1, '{ZERO, 1'b1}},
      '{'{OP_REM, DW'(17), -DW'(5)}, 1'b1, '{ZERO, 1'b1}},
      '{'{OP_REM, MAXV, MAXV}, 1'b1, '{ZERO, 1'b0}},
      '{'{OP_ABS, MINV, ONES}, 1'b1, '{MINV, 1'b0}},
      '{'{OP_ABS, ONES, ZERO}, 1'b1, '{ONE, 1'b0}},
      '{'{OP_ABS, MAXV, MINV}, 1'b1, '{MAXV, 1'b0}},
      '{'{3'd6, MAXV, ONES}, 1'b1, '{ZERO, 1'b0}},
      '{'{3'd7, ONES, ONES}, 1'b1, '{ZERO, 1'b0}}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].res);

    // pause until the pipe is empty
    s_axis_tvalid <= 1'b0;
    drain_results();

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 600) begin
        s_axis_tvalid <= 1'b0;
        drain_results();
      end
      if (n == N_RANDOM - 200) quiet_tail = 1'b1;
      it.op = OPCODE_W'($urandom_range(0, 7));
      it.a = rand_operand();
      it.b = rand_operand();
      send_item(it, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 100_000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (2 * LATENCY) @(negedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      n_errors++;
    end

    $display("Ran %0d items through all opcodes, including unused ones, with overflow,",
             n_items);
    $display("zero-divisor and negative-remainder cases; %0d results checked.", n_results);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
